@@ design/mtg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and helper functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int WORD_W          = 32;
  localparam int CNT_W           = 7;
  localparam int ADDR_W          = 10;
  localparam int MT_N            = 624;
  localparam int MT_M            = 397;
  localparam int SEED_SHIFT      = 30;
  localparam int MAX_BURST_DEF   = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [WORD_W-1:0] MT_MULT   = 32'd1812433253;
  localparam logic [WORD_W-1:0] MT_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] MT_UPPER  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] MT_LOWER  = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hEFC6_0000;

  typedef struct packed {
    logic              reseed;
    logic [WORD_W-1:0] seed;
    logic [CNT_W-1:0]  count;
  } req_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // next index, wrapping at the end of the state
  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    if (a == ADDR_W'(MT_N - 1)) begin
      r = '0;
    end else begin
      r = a + ADDR_W'(1);
    end
    return r;
  endfunction

  // index plus the twist offset, wrapped
  function automatic logic [ADDR_W-1:0] wrap_add_m(input logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] s;
    logic [ADDR_W-1:0] r;
    s = {1'b0, a} + (ADDR_W + 1)'(MT_M);
    if (s >= (ADDR_W + 1)'(MT_N)) begin
      r = ADDR_W'(s - (ADDR_W + 1)'(MT_N));
    end else begin
      r = ADDR_W'(s);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/mtg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_front
// Request intake: takes a beat when the queue has room and clamps the count.
// ----------------------------------------------------------------------------
module mtg_front #(
  parameter int MAX_BURST = mtg_pkg::MAX_BURST_DEF
) (
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_reseed,
  input  wire logic [mtg_pkg::WORD_W-1:0] in_seed_value,
  input  wire logic [mtg_pkg::CNT_W-1:0]  in_word_count,
  input  wire logic                      q_full,
  output logic                           q_push,
  output mtg_pkg::req_t                  q_req
);

  localparam logic [mtg_pkg::CNT_W-1:0] BURST_LIM = mtg_pkg::CNT_W'(MAX_BURST);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_req.reseed = in_reseed;
    q_req.seed   = in_seed_value;
    if (in_word_count > BURST_LIM) begin
      q_req.count = BURST_LIM;
    end else begin
      q_req.count = in_word_count;
    end
  end

endmodule
`default_nettype wire

@@ design/mtg_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_queue
// Short request queue between intake and the generator engine.
// ----------------------------------------------------------------------------
module mtg_queue #(
  parameter int DEPTH = mtg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mtg_pkg::req_t push_data,
  output logic               full,
  input  wire logic          pop,
  output mtg_pkg::req_t      pop_data,
  output logic               empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mtg_pkg::req_t     slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("queue fill above depth");

  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push && fill_r == CNT_W'(1)) |=> empty)
    else $error("queue not empty after last pop");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !empty)
    else $error("queue empty after push");
`endif

endmodule
`default_nettype wire

@@ design/mtg_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtg_engine
// State memory, seeding sequencer and twist/temper pipeline with output reg.
// ----------------------------------------------------------------------------
module mtg_engine (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_empty,
  input  wire mtg_pkg::req_t              q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [mtg_pkg::WORD_W-1:0]      out_random_word,
  output logic                            out_last_word
);

  localparam int WW = mtg_pkg::WORD_W;
  localparam int AW = mtg_pkg::ADDR_W;
  localparam int CW = mtg_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SEED_MUL = 6'b000010,
    S_SEED_ADD = 6'b000100,
    S_PRIME    = 6'b001000,
    S_LOAD     = 6'b010000,
    S_RUN      = 6'b100000
  } state_t;

  logic [WW-1:0] mem [mtg_pkg::MT_N];

  state_t        state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] nxt1_r, nxt1_nxt;
  logic [AW-1:0] m_r, m_nxt;
  logic [AW-1:0] seed_idx_r, seed_idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [WW-1:0] prev_r, prev_nxt;
  logic [WW-1:0] prod_r, prod_nxt;
  logic [WW-1:0] cur_r, cur_nxt;
  logic [WW-1:0] out_word_r, out_word_nxt;
  logic          out_last_r, out_last_nxt;
  logic [WW-1:0] rd_a_r, rd_b_r;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [WW-1:0] mem_wd;
  logic          re_a, re_b;
  logic [AW-1:0] ra, rb;
  logic          out_free;
  logic [WW-1:0] seed_mix, seed_word, mix_y, twisted;

  assign out_free        = !out_valid_r || !out_stall;
  assign seed_mix        = prev_r ^ (prev_r >> mtg_pkg::SEED_SHIFT);
  assign seed_word       = prod_r + WW'(seed_idx_r);
  assign mix_y           = (cur_r & mtg_pkg::MT_UPPER) | (rd_a_r & mtg_pkg::MT_LOWER);
  assign twisted         = rd_b_r ^ (mix_y >> 1) ^ (mix_y[0] ? mtg_pkg::MT_MATRIX : '0);
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;
  assign out_last_word   = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    nxt1_nxt      = nxt1_r;
    m_nxt         = m_r;
    seed_idx_nxt  = seed_idx_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wa        = pos_r;
    mem_wd        = twisted;
    re_a          = 1'b0;
    ra            = pos_r;
    re_b          = 1'b0;
    rb            = m_r;
    q_pop         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cnt_nxt = q_data.count;
          if (q_data.reseed) begin
            mem_we       = 1'b1;
            mem_wa       = '0;
            mem_wd       = q_data.seed;
            prev_nxt     = q_data.seed;
            seed_idx_nxt = AW'(1);
            state_nxt    = S_SEED_MUL;
          end else if (q_data.count != '0) begin
            state_nxt = S_PRIME;
          end
        end
      end
      S_SEED_MUL: begin
        prod_nxt  = seed_mix * mtg_pkg::MT_MULT;
        state_nxt = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        mem_we   = 1'b1;
        mem_wa   = seed_idx_r;
        mem_wd   = seed_word;
        prev_nxt = seed_word;
        if (seed_idx_r == AW'(mtg_pkg::MT_N - 1)) begin
          pos_nxt   = '0;
          state_nxt = (cnt_r != '0) ? S_PRIME : S_IDLE;
        end else begin
          seed_idx_nxt = seed_idx_r + AW'(1);
          state_nxt    = S_SEED_MUL;
        end
      end
      S_PRIME: begin
        re_a      = 1'b1;
        ra        = pos_r;
        nxt1_nxt  = mtg_pkg::wrap_inc(pos_r);
        m_nxt     = mtg_pkg::wrap_add_m(pos_r);
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cur_nxt   = rd_a_r;
        re_a      = 1'b1;
        ra        = nxt1_r;
        re_b      = 1'b1;
        rb        = m_r;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (out_free) begin
          mem_we        = 1'b1;
          mem_wa        = pos_r;
          mem_wd        = twisted;
          out_valid_nxt = 1'b1;
          out_word_nxt  = mtg_pkg::temper(twisted);
          out_last_nxt  = (cnt_r == CW'(1));
          cur_nxt       = rd_a_r;
          pos_nxt       = nxt1_r;
          cnt_nxt       = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            re_a     = 1'b1;
            ra       = mtg_pkg::wrap_inc(nxt1_r);
            re_b     = 1'b1;
            rb       = mtg_pkg::wrap_inc(m_r);
            nxt1_nxt = mtg_pkg::wrap_inc(nxt1_r);
            m_nxt    = mtg_pkg::wrap_inc(m_r);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nxt1_r     <= nxt1_nxt;
    m_r        <= m_nxt;
    seed_idx_r <= seed_idx_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (re_a) begin
      rd_a_r <= mem[ra];
    end
    if (re_b) begin
      rd_b_r <= mem[rb];
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < AW'(mtg_pkg::MT_N))
    else $error("position out of range");

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (cnt_r != '0))
    else $error("burst running with zero count");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && re_b) |-> (mem_wa != rb && mem_wa != ra))
    else $error("read and write of the same state entry");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && out_free && cnt_r == CW'(1)) |=> (state_r == S_IDLE && out_last_r))
    else $error("burst did not end on last beat");
`endif

endmodule
`default_nettype wire

@@ design/mersenne_twister_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator: optional reseed, then a burst of tempered 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per request (reseed flag, seed, word count). Counts above
//           MAX_BURST are clamped; a count of zero yields no output beats.
//   out_* : one beat per word; out_last_word marks the final word of a burst.
//   Requests pass through a QUEUE_DEPTH-entry queue, so new beats are taken
//   while the engine is busy until the queue fills (in_stall high).
//   Reseeding fills the 624-entry state entry by entry, with a multiply step
//   and an add step per entry of the seeding recurrence.
//   A burst then runs through the PRIME and LOAD states into RUN after the
//   request leaves the queue, and delivers one word per cycle while the
//   output is not stalled; the state memory's two read ports and one write
//   port carry one twist per cycle under the same condition.
//   While out_stall is high and a word is held, that word stays in the output
//   register and the twist pipeline holds.
//   Reset (rst_n low, synchronous) empties the queue, drops any burst and
//   sets the position to zero. The state is undefined until the first
//   reseed, and a reseed must come before the first generation.
// ----------------------------------------------------------------------------
module mersenne_twister_generator #(
  parameter int MAX_BURST   = mtg_pkg::MAX_BURST_DEF,
  parameter int QUEUE_DEPTH = mtg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_reseed,
  input  wire logic [mtg_pkg::WORD_W-1:0] in_seed_value,
  input  wire logic [mtg_pkg::CNT_W-1:0]  in_word_count,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [mtg_pkg::WORD_W-1:0]      out_random_word,
  output logic                            out_last_word
);

  logic          q_push, q_full, q_pop, q_empty;
  mtg_pkg::req_t q_req, q_head;

  mtg_front #(
    .MAX_BURST(MAX_BURST)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_reseed     (in_reseed),
    .in_seed_value (in_seed_value),
    .in_word_count (in_word_count),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_req         (q_req)
  );

  mtg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_req),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  mtg_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word),
    .out_last_word   (out_last_word)
  );

endmodule
`default_nettype wire

@@ verif/mersenne_twister_generator_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mersenne_twister_generator_checker
// Watches the request and word channels of the generator. Every accepted
// request is run through a local MT19937 state copy (seeding, twist and
// tempering), and the resulting words are queued. Every accepted word beat
// is compared field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic                       in_reseed,
  input  wire logic [mtg_pkg::WORD_W-1:0] in_seed_value,
  input  wire logic [mtg_pkg::CNT_W-1:0]  in_word_count,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [mtg_pkg::WORD_W-1:0] out_random_word,
  input  wire logic                       out_last_word,
  output int                              fail_count,
  output int                              words_due
);

  typedef struct packed {
    logic [mtg_pkg::WORD_W-1:0] word;
    logic                       last;
  } word_beat_t;

  logic [mtg_pkg::WORD_W-1:0] mt_state [mtg_pkg::MT_N];
  logic [mtg_pkg::ADDR_W-1:0] word_pos;
  word_beat_t                 expected_words [$];
  word_beat_t                 want;

  initial begin
    fail_count = 0;
    words_due  = 0;
    word_pos   = '0;
  end

  function automatic void seed_state(input logic [mtg_pkg::WORD_W-1:0] seed);
    logic [mtg_pkg::WORD_W-1:0] prev;
    mt_state[0] = seed;
    for (int i = 1; i < mtg_pkg::MT_N; i++) begin
      prev        = mt_state[i-1];
      mt_state[i] = mtg_pkg::MT_MULT * (prev ^ (prev >> mtg_pkg::SEED_SHIFT))
                    + mtg_pkg::WORD_W'(i);
    end
  endfunction

  function automatic logic [mtg_pkg::WORD_W-1:0] temper_word(
    input logic [mtg_pkg::WORD_W-1:0] raw
  );
    logic [mtg_pkg::WORD_W-1:0] t;
    t = raw;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & 32'h9D2C_5680);
    t = t ^ ((t << 15) & 32'hEFC6_0000);
    t = t ^ (t >> 18);
    return t;
  endfunction

  function automatic logic [mtg_pkg::WORD_W-1:0] twist_next_word();
    int                         p;
    int                         p1;
    int                         pm;
    logic [mtg_pkg::WORD_W-1:0] y;
    logic [mtg_pkg::WORD_W-1:0] v;
    p  = (int'(word_pos) < mtg_pkg::MT_N) ? int'(word_pos) : 0;
    p1 = (p + 1 < mtg_pkg::MT_N) ? p + 1 : 0;
    pm = p + mtg_pkg::MT_M;
    if (pm >= mtg_pkg::MT_N) begin
      pm = pm - mtg_pkg::MT_N;
    end
    y = (mt_state[p] & mtg_pkg::MT_UPPER) | (mt_state[p1] & mtg_pkg::MT_LOWER);
    v = mt_state[pm] ^ (y >> 1) ^ (y[0] ? mtg_pkg::MT_MATRIX : '0);
    mt_state[p] = v;
    word_pos    = mtg_pkg::ADDR_W'(p1);
    return temper_word(v);
  endfunction

  function automatic void predict_request(input logic                       reseed,
                                          input logic [mtg_pkg::WORD_W-1:0] seed,
                                          input logic [mtg_pkg::CNT_W-1:0]  count);
    int         n;
    word_beat_t beat;
    if (reseed) begin
      seed_state(seed);
      word_pos = '0;
    end
    n = (int'(count) > mtg_pkg::MAX_BURST_DEF) ? mtg_pkg::MAX_BURST_DEF : int'(count);
    for (int k = 0; k < n; k++) begin
      beat.word = twist_next_word();
      beat.last = (k == n - 1);
      expected_words.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_words.delete();
      word_pos = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word beat: out_random_word %h, out_last_word %b",
                 out_random_word, out_last_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_random_word !== want.word) begin
            $error("out_random_word mismatch: expected %h, actual %h",
                   want.word, out_random_word);
            fail_count++;
          end
          if (out_last_word !== want.last) begin
            $error("out_last_word mismatch: expected %b, actual %b",
                   want.last, out_last_word);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_request(in_reseed, in_seed_value, in_word_count);
      end
    end
    words_due = expected_words.size();
  end

endmodule

@@ verif/mersenne_twister_generator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mersenne_twister_generator_tb
// Drives seeded requests into the generator with random gaps on both sides,
// including one long receiver hold-off that backs up the request queue.
// A directed set covers seed and count extremes, zero counts, saturated
// counts and a state wrap; a random set follows. The checker predicts and
// compares every word beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_tb;

  localparam int RANDOM_REQUESTS = 440;
  localparam int HOLD_AT         = 60;
  localparam int HOLD_CYCLES     = 500;
  localparam int TAIL_CYCLES     = 4000;
  localparam int CYCLE_LIMIT     = 8_000_000;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_reseed;
  logic [mtg_pkg::WORD_W-1:0] in_seed_value;
  logic [mtg_pkg::CNT_W-1:0]  in_word_count;
  logic                       out_valid;
  logic                       out_stall;
  logic [mtg_pkg::WORD_W-1:0] out_random_word;
  logic                       out_last_word;

  int fail_count;
  int words_due;
  int requests_taken = 0;
  int cycle_count    = 0;

  always #10 clk = ~clk;

  mersenne_twister_generator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_reseed       (in_reseed),
    .in_seed_value   (in_seed_value),
    .in_word_count   (in_word_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word),
    .out_last_word   (out_last_word)
  );

  mersenne_twister_generator_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_reseed       (in_reseed),
    .in_seed_value   (in_seed_value),
    .in_word_count   (in_word_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word),
    .out_last_word   (out_last_word),
    .fail_count      (fail_count),
    .words_due       (words_due)
  );

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic                       reseed,
                              input logic [mtg_pkg::WORD_W-1:0] seed,
                              input logic [mtg_pkg::CNT_W-1:0]  count);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_reseed     <= reseed;
    in_seed_value <= seed;
    in_word_count <= count;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_taken++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mersenne_twister_generator test failed");
      $finish;
    end
  end

  initial begin : receiver
    int run_left;
    int gap_left;
    int hold_left;
    bit hold_done;
    run_left  = 0;
    gap_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && requests_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        out_stall <= 1'b0;
      end else begin
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 8);
        gap_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int                        pick;
    logic [mtg_pkg::CNT_W-1:0] count;
    in_valid      <= 1'b0;
    in_reseed     <= 1'b0;
    in_seed_value <= '0;
    in_word_count <= '0;
    rst_n         <= 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(1'b1, 32'd5489, 7'd1);
    send_request(1'b0, 32'h0000_0000, 7'd64);
    send_request(1'b0, 32'hFFFF_FFFF, 7'd0);
    send_request(1'b1, 32'h0000_0000, 7'd0);
    send_request(1'b0, 32'h5A5A_5A5A, 7'd3);
    send_request(1'b1, 32'hFFFF_FFFF, 7'd127);
    send_request(1'b0, 32'h0000_0000, 7'd65);
    send_request(1'b0, 32'h0000_0000, 7'd100);
    send_request(1'b1, 32'h8000_0000, 7'd2);
    // enough words to wrap the state position
    send_request(1'b1, 32'h1234_5678, 7'd64);
    for (int i = 0; i < 10; i++) begin
      send_request(1'b0, $urandom, 7'd64);
    end
    send_request(1'b0, $urandom, 7'd1);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        count = '0;
      end else if (pick < 20) begin
        count = mtg_pkg::CNT_W'($urandom_range(65, 127));
      end else if (pick < 35) begin
        count = mtg_pkg::CNT_W'(mtg_pkg::MAX_BURST_DEF);
      end else begin
        count = mtg_pkg::CNT_W'($urandom_range(1, 63));
      end
      send_request($urandom_range(0, 19) == 0, $urandom, count);
    end
    in_valid <= 1'b0;

    wait (words_due == 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("mersenne_twister_generator test passed");
    end else begin
      $display("mersenne_twister_generator test failed");
    end
    $finish;
  end

endmodule
